FILE: rtl/imu_cf_pkg.sv
// package for the imu tilt estimator: sequencer states, constants and helper functions
package imu_cf_pkg;

	// default parameter values
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// fixed-point constants
	localparam int GYRO_K32   = 327860;      // 1/13100 degree per lsb, q0.32
	localparam int YAW_K48    = 375012605;   // 1/13100 degree per lsb in radians, q.48
	localparam int W_OLD      = 1009317315;  // 0.94 in q.30
	localparam int W_NEW      = 64424509;    // 0.06 in q.30
	localparam int RECIP6     = 699051;      // ceil(2^22 / 6)
	localparam int RECIP6_SH  = 22;
	localparam int SQRT_STEPS = 29;          // one result bit per step, 58-bit radicand
	localparam int SQRT_W     = 58;

	// register indices
	localparam logic [2:0] REG_GYRO_OFF_X = 3'd0;
	localparam logic [2:0] REG_GYRO_OFF_Y = 3'd1;
	localparam logic [2:0] REG_GYRO_OFF_Z = 3'd2;
	localparam logic [2:0] REG_ACC_TRIM_X = 3'd3;
	localparam logic [2:0] REG_ACC_TRIM_Y = 3'd4;

	// trim reset values, 2.0 and -0.9 degrees in q16.16
	localparam logic signed [24:0] TRIM_X_RST = 25'sd131072;
	localparam logic signed [24:0] TRIM_Y_RST = -25'sd58982;

	localparam logic signed [67:0] SAT_MAX = 68'sh0_0000_0000_7fff_ffff;
	localparam logic signed [67:0] SAT_MIN = -68'sh0_0000_0000_8000_0000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GX,
		ST_GY,
		ST_GZ,
		ST_X30,
		ST_SQ,
		ST_X2,
		ST_CUBE,
		ST_X3,
		ST_DIV,
		ST_SIN,
		ST_MX,
		ST_MY,
		ST_MAPPLY,
		ST_SSX,
		ST_SSY,
		ST_SSZ,
		ST_NORM,
		ST_NSQ,
		ST_NN,
		ST_DIFF,
		ST_ROOT,
		ST_CINIT,
		ST_CORDIC,
		ST_ACC,
		ST_BX,
		ST_BXN,
		ST_BY,
		ST_BYN,
		ST_FIN,
		ST_DONE
	} state_t;

	// clamp to the 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7fff_ffff;
		end else if (v < SAT_MIN) begin
			r = -32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// arithmetic right shift, rounding half up
	function automatic logic signed [67:0] rsh68(input logic signed [67:0] v, input int s);
		logic signed [67:0] rnd;
		rnd = (s == 0) ? 68'sd0 : (68'sd1 <<< (s - 1));
		return (v + rnd) >>> s;
	endfunction

	// arctan(2^-i) in q.24 degrees
	function automatic logic [29:0] atan_q24(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd754974720;
			5'd1:  r = 30'd445687602;
			5'd2:  r = 30'd235489088;
			5'd3:  r = 30'd119537938;
			5'd4:  r = 30'd60000934;
			5'd5:  r = 30'd30029717;
			5'd6:  r = 30'd15018523;
			5'd7:  r = 30'd7509720;
			5'd8:  r = 30'd3754917;
			5'd9:  r = 30'd1877466;
			5'd10: r = 30'd938734;
			5'd11: r = 30'd469367;
			5'd12: r = 30'd234684;
			5'd13: r = 30'd117342;
			5'd14: r = 30'd58671;
			5'd15: r = 30'd29335;
			5'd16: r = 30'd14668;
			5'd17: r = 30'd7334;
			5'd18: r = 30'd3667;
			5'd19: r = 30'd1833;
			5'd20: r = 30'd917;
			5'd21: r = 30'd458;
			5'd22: r = 30'd229;
			5'd23: r = 30'd115;
			5'd24: r = 30'd57;
			5'd25: r = 30'd29;
			5'd26: r = 30'd14;
			5'd27: r = 30'd7;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			5'd30: r = 30'd1;
			5'd31: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/imu_complementary_filter_top.sv
// imu tilt estimator top level: sequencer around one shared multiplier, sqrt and cordic unit
// One item at a time: in_stall keeps a new item out until the last one has left the done state.
//   When the vector norm is zero the per-axis square roots and cordic passes are skipped.
// The 29-step square roots, one for the norm and one per axis, and the cordic passes, one per
//   axis, all run on the shared datapath. in_stall is high while an item is at work.
// Reset: asynchronous active low; angles and seed flag clear, offsets clear, trims load 2.0 / -0.9 deg.
module imu_complementary_filter_top
	import imu_cf_pkg::*;
#(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [24:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        acc_x_raw,
	input  logic [15:0]        acc_y_raw,
	input  logic [15:0]        acc_z_raw,
	input  logic [15:0]        rate_x_raw,
	input  logic [15:0]        rate_y_raw,
	input  logic [15:0]        rate_z_raw,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] tilt_x,
	output logic signed [31:0] tilt_y
);

	localparam int GSHIFT = 32 - FRAC_BITS;
	localparam int ASHIFT = 24 - FRAC_BITS;
	localparam int A_RND  = (ASHIFT == 0) ? 0 : (1 << (ASHIFT - 1));
	localparam int T_UP   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int T_DN   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int T_RND  = (T_DN == 0) ? 0 : (1 << (T_DN - 1));

	state_t state_q, state_d;

	// configuration registers
	logic signed [15:0] gyro_off_x_q, gyro_off_y_q, gyro_off_z_q;
	logic signed [24:0] trim_x_q, trim_y_q;

	// control and filter state
	logic [4:0]         cnt_q;
	logic               axis_q;
	logic               seeded_q;
	logic signed [31:0] angle_x_q, angle_y_q;
	logic               out_valid_q;
	logic signed [31:0] tilt_x_q, tilt_y_q;

	// datapath registers
	logic signed [17:0] rx_q, ry_q, rz_q;
	logic signed [16:0] ax_q, ay_q, az_q;
	logic signed [67:0] prod_q, bsum_q;
	logic signed [33:0] x30_q, t_q, s30_q, mx_q;
	logic [33:0]        sq_x_q, sq_y_q;
	logic [16:0]        norm_q;
	logic [SQRT_W-1:0]  rem_q, root_q, bit_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic signed [33:0] accx_q, accy_q;

	// shared multiplier operands
	logic signed [33:0] mul_a, mul_b;

	logic in_fire, out_free, cnt_last_sqrt, cnt_last_cordic;

	assign in_fire         = in_valid && !in_stall;
	assign out_free        = !out_valid_q || !out_stall;
	assign cnt_last_sqrt   = (cnt_q == 5'(SQRT_STEPS - 1));
	assign cnt_last_cordic = (cnt_q == 5'(CORDIC_STEPS - 1));

	// sample words negated, gyro offsets removed
	logic signed [17:0] rx_in, ry_in, rz_in;
	logic signed [16:0] ax_in, ay_in, az_in;
	always_comb begin
		rx_in = -$signed({{2{rate_x_raw[15]}}, rate_x_raw}) - 18'(gyro_off_x_q);
		ry_in = -$signed({{2{rate_y_raw[15]}}, rate_y_raw}) - 18'(gyro_off_y_q);
		rz_in = -$signed({{2{rate_z_raw[15]}}, rate_z_raw}) - 18'(gyro_off_z_q);
		ax_in = -$signed({acc_x_raw[15], acc_x_raw});
		ay_in = -$signed({acc_y_raw[15], acc_y_raw});
		az_in = -$signed({acc_z_raw[15], acc_z_raw});
	end

	// square root step, one result bit per cycle
	logic [SQRT_W-1:0] sq_trial;
	logic              sq_ge;
	assign sq_trial = root_q + bit_q;
	assign sq_ge    = (rem_q >= sq_trial);

	// cordic vectoring step
	logic signed [33:0] cx_sh, cy_sh, c_atan;
	assign cx_sh  = cx_q >>> cnt_q;
	assign cy_sh  = cy_q >>> cnt_q;
	assign c_atan = $signed({4'b0, atan_q24(cnt_q)});

	// accelerometer angle from cordic result, trims scaled to the output fraction
	logic signed [33:0] z_rnd, trim_x_s, trim_y_s;
	always_comb begin
		z_rnd    = (cz_q + 34'(A_RND)) >>> ASHIFT;
		trim_x_s = ((34'(trim_x_q) + 34'(T_RND)) >>> T_DN) <<< T_UP;
		trim_y_s = ((34'(trim_y_q) + 34'(T_RND)) >>> T_DN) <<< T_UP;
	end

	// misc datapath terms
	logic signed [33:0] t_abs, div_q, sq_diff;
	logic signed [67:0] blend_sum;
	always_comb begin
		t_abs     = t_q[33] ? -t_q : t_q;
		div_q     = 34'(prod_q >>> RECIP6_SH);
		sq_diff   = $signed(prod_q[33:0] - (axis_q ? sq_y_q : sq_x_q));
		blend_sum = rsh68(bsum_q + prod_q, 30);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_GX;
			ST_GX:     state_d = ST_GY;
			ST_GY:     state_d = ST_GZ;
			ST_GZ:     state_d = ST_X30;
			ST_X30:    state_d = ST_SQ;
			ST_SQ:     state_d = ST_X2;
			ST_X2:     state_d = ST_CUBE;
			ST_CUBE:   state_d = ST_X3;
			ST_X3:     state_d = ST_DIV;
			ST_DIV:    state_d = ST_SIN;
			ST_SIN:    state_d = ST_MX;
			ST_MX:     state_d = ST_MY;
			ST_MY:     state_d = ST_MAPPLY;
			ST_MAPPLY: state_d = ST_SSX;
			ST_SSX:    state_d = ST_SSY;
			ST_SSY:    state_d = ST_SSZ;
			ST_SSZ:    state_d = ST_NORM;
			ST_NORM:   if (cnt_last_sqrt) state_d = ST_NSQ;
			ST_NSQ:    state_d = ST_NN;
			ST_NN:     state_d = ST_DIFF;
			ST_DIFF:   state_d = (norm_q == '0) ? ST_ACC : ST_ROOT;
			ST_ROOT:   if (cnt_last_sqrt) state_d = ST_CINIT;
			ST_CINIT:  state_d = ST_CORDIC;
			ST_CORDIC: if (cnt_last_cordic) state_d = ST_ACC;
			ST_ACC:    state_d = axis_q ? ST_BX : ST_NN;
			ST_BX:     state_d = ST_BXN;
			ST_BXN:    state_d = ST_BY;
			ST_BY:     state_d = ST_BYN;
			ST_BYN:    state_d = ST_FIN;
			ST_FIN:    state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake and multiplier operands
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_GX:     begin mul_a = 34'(rx_q);      mul_b = 34'(GYRO_K32); end
			ST_GY:     begin mul_a = 34'(ry_q);      mul_b = 34'(GYRO_K32); end
			ST_GZ:     begin mul_a = 34'(rz_q);      mul_b = 34'(YAW_K48); end
			ST_SQ:     begin mul_a = x30_q;          mul_b = x30_q; end
			ST_CUBE:   begin mul_a = t_q;            mul_b = x30_q; end
			ST_DIV:    begin mul_a = t_abs;          mul_b = 34'(RECIP6); end
			ST_MX:     begin mul_a = 34'(angle_y_q); mul_b = s30_q; end
			ST_MY:     begin mul_a = 34'(angle_x_q); mul_b = s30_q; end
			ST_MAPPLY: begin mul_a = 34'(ax_q);      mul_b = 34'(ax_q); end
			ST_SSX:    begin mul_a = 34'(ay_q);      mul_b = 34'(ay_q); end
			ST_SSY:    begin mul_a = 34'(az_q);      mul_b = 34'(az_q); end
			ST_NN:     begin
				mul_a = $signed({17'b0, norm_q});
				mul_b = $signed({17'b0, norm_q});
			end
			ST_BX:     begin mul_a = 34'(angle_x_q); mul_b = 34'(W_OLD); end
			ST_BXN:    begin mul_a = accx_q;         mul_b = 34'(W_NEW); end
			ST_BY:     begin mul_a = 34'(angle_y_q); mul_b = 34'(W_OLD); end
			ST_BYN:    begin mul_a = accy_q;         mul_b = 34'(W_NEW); end
			default:   ;
		endcase
	end

	// sequencer, filter state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			axis_q       <= 1'b0;
			seeded_q     <= 1'b0;
			angle_x_q    <= '0;
			angle_y_q    <= '0;
			out_valid_q  <= 1'b0;
			gyro_off_x_q <= '0;
			gyro_off_y_q <= '0;
			gyro_off_z_q <= '0;
			trim_x_q     <= TRIM_X_RST;
			trim_y_q     <= TRIM_Y_RST;
		end else begin
			state_q <= state_d;

			// configuration writes, unknown index ignored
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_GYRO_OFF_X: gyro_off_x_q <= cfg_data[15:0];
					REG_GYRO_OFF_Y: gyro_off_y_q <= cfg_data[15:0];
					REG_GYRO_OFF_Z: gyro_off_z_q <= cfg_data[15:0];
					REG_ACC_TRIM_X: trim_x_q     <= cfg_data;
					REG_ACC_TRIM_Y: trim_y_q     <= cfg_data;
					default: ;
				endcase
			end

			// step counter for square root and cordic
			unique case (state_q)
				ST_SSZ, ST_DIFF, ST_CINIT: cnt_q <= '0;
				ST_NORM, ST_ROOT, ST_CORDIC: cnt_q <= cnt_q + 5'd1;
				default: ;
			endcase

			if (in_fire) begin
				axis_q <= 1'b0;
			end else if (state_q == ST_ACC) begin
				axis_q <= 1'b1;
			end

			// angle updates
			unique case (state_q)
				ST_GY: angle_x_q <= sat32(68'(angle_x_q) + rsh68(prod_q, GSHIFT));
				ST_GZ: angle_y_q <= sat32(68'(angle_y_q) + rsh68(prod_q, GSHIFT));
				ST_MAPPLY: begin
					angle_x_q <= sat32(68'(angle_x_q) + 68'(mx_q));
					angle_y_q <= sat32(68'(angle_y_q) - rsh68(prod_q, 30));
				end
				ST_BY: angle_x_q <= seeded_q ? sat32(blend_sum) : sat32(68'(accx_q));
				ST_FIN: begin
					angle_y_q <= seeded_q ? sat32(blend_sum) : sat32(68'(accy_q));
					seeded_q  <= 1'b1;
				end
				default: ;
			endcase

			// output item handshake
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					rx_q <= rx_in;
					ry_q <= ry_in;
					rz_q <= rz_in;
					ax_q <= ax_in;
					ay_q <= ay_in;
					az_q <= az_in;
				end
			end
			// yaw sine x - x^3/6 in q.30
			ST_X30: x30_q <= 34'(rsh68(prod_q, 18));
			ST_X2:  t_q   <= 34'(rsh68(prod_q, 30));
			ST_X3:  t_q   <= 34'(rsh68(prod_q, 30));
			ST_SIN: s30_q <= x30_q - (t_q[33] ? -div_q : div_q);
			ST_MY:  mx_q  <= 34'(rsh68(prod_q, 30));
			// squared norm
			ST_SSX: sq_x_q <= prod_q[33:0];
			ST_SSY: sq_y_q <= prod_q[33:0];
			ST_SSZ: begin
				rem_q  <= SQRT_W'(sq_x_q) + SQRT_W'(sq_y_q) + SQRT_W'(prod_q[33:0]);
				root_q <= '0;
				bit_q  <= SQRT_W'(1) << (2 * (SQRT_STEPS - 1));
			end
			ST_NORM, ST_ROOT: begin
				if (sq_ge) begin
					rem_q  <= rem_q - sq_trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_NSQ: norm_q <= root_q[16:0];
			// cosine leg for the asin, zero norm gives a zero angle
			ST_DIFF: begin
				if (norm_q == '0) begin
					cz_q <= '0;
				end else begin
					rem_q  <= SQRT_W'(sq_diff) << 24;
					root_q <= '0;
					bit_q  <= SQRT_W'(1) << (2 * (SQRT_STEPS - 1));
				end
			end
			ST_CINIT: begin
				cx_q <= $signed({6'b0, root_q[27:0]});
				cy_q <= 34'(axis_q ? ay_q : ax_q) <<< 12;
				cz_q <= '0;
			end
			ST_CORDIC: begin
				if (!cy_q[33]) begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					cz_q <= cz_q + c_atan;
				end else begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					cz_q <= cz_q - c_atan;
				end
			end
			ST_ACC: begin
				if (axis_q) begin
					accy_q <= z_rnd - trim_y_s;
				end else begin
					accx_q <= -z_rnd - trim_x_s;
				end
			end
			ST_BXN, ST_BYN: bsum_q <= prod_q;
			ST_DONE: begin
				if (out_free) begin
					tilt_x_q <= angle_x_q;
					tilt_y_q <= sat32(-68'(angle_y_q));
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign tilt_x    = tilt_x_q;
	assign tilt_y    = tilt_y_q;

`ifndef ASSERT_OFF
	// an accepted item always starts the gyro step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_GX))
		else $error("sequencer did not start on accepted item");

	// a result only appears from the final state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("output valid rose outside the final state");

	// the filter never drops back to unseeded
	a_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |=> seeded_q)
		else $error("seed flag cleared");

	// cordic step count stays inside the table
	a_cordic_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORDIC) |-> (cnt_q <= 5'(CORDIC_STEPS - 1)))
		else $error("cordic step counter overran");
`endif

endmodule

FILE: tb/sv/imu_complementary_filter_checker.sv
// checker for the imu tilt estimator: predicts each result and compares the output item
`timescale 1ns / 1ps

module imu_complementary_filter_checker
	import imu_cf_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [24:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [15:0]        acc_x_raw,
	input  logic [15:0]        acc_y_raw,
	input  logic [15:0]        acc_z_raw,
	input  logic [15:0]        rate_x_raw,
	input  logic [15:0]        rate_y_raw,
	input  logic [15:0]        rate_z_raw,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] tilt_x,
	input  logic signed [31:0] tilt_y,
	output int                 fail_count,
	output int                 pending
);

	localparam int GYRO_SHIFT = 16;
	localparam int ACC_SHIFT  = 8;
	localparam longint RATE_DEG_Q32 = 327860;
	localparam longint RATE_RAD_Q48 = 375012605;
	localparam longint BLEND_OLD    = 1009317315;
	localparam longint BLEND_NEW    = 64424509;
	localparam longint INT32_HI     = 64'sd2147483647;
	localparam longint INT32_LO     = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} tilt_pair_t;

	// arctan(2^-i) in q.24 degrees
	localparam longint ARCTAN_DEG [32] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
		58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
		14, 7, 4, 2, 1, 0};

	tilt_pair_t expected_tilts[$];

	logic signed [15:0] off_x, off_y, off_z;
	logic signed [24:0] trim_x, trim_y;
	longint             run_x, run_y;
	bit                 started;

	function automatic longint round_shift(longint v, int s);
		if (s == 0) return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > INT32_HI) return INT32_HI;
		if (v < INT32_LO) return INT32_LO;
		return v;
	endfunction

	function automatic longint negated(logic [15:0] w);
		longint s;
		s = longint'($signed(w));
		return -s;
	endfunction

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// asin(a / n) in q.24 degrees by cordic vectoring
	function automatic longint tilt_deg(longint a, longint unsigned n);
		longint unsigned aa;
		longint x, y, z, xs, ys;
		int steps;
		aa = (a < 0) ? longint'(-a) : longint'(a);
		z = 0;
		steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
		if (n == 0) return 0;
		x = longint'(int_root((n * n - aa * aa) << 24));
		y = a * 4096;
		for (int i = 0; i < steps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN_DEG[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN_DEG[i];
			end
		end
		return z;
	endfunction

	// sine of the yaw step in q.30
	function automatic longint yaw_sin(longint rz);
		longint x30, x2, x3;
		x30 = round_shift(rz * RATE_RAD_Q48, 18);
		x2  = round_shift(x30 * x30, 30);
		x3  = round_shift(x2 * x30, 30);
		return x30 - x3 / 6;
	endfunction

	task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = expected_tilts.size();

	// model the filter on each accepted item and check each output item
	always @(posedge clk or negedge arst_n) begin
		longint rx, ry, rz, ax, ay, az, s30, mx, my, ex, ey;
		longint unsigned norm;
		tilt_pair_t p, got;
		if (!arst_n) begin
			off_x = 0;
			off_y = 0;
			off_z = 0;
			trim_x = TRIM_X_RST;
			trim_y = TRIM_Y_RST;
			run_x = 0;
			run_y = 0;
			started = 0;
			fail_count = 0;
			expected_tilts.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_GYRO_OFF_X: off_x = cfg_data[15:0];
					REG_GYRO_OFF_Y: off_y = cfg_data[15:0];
					REG_GYRO_OFF_Z: off_z = cfg_data[15:0];
					REG_ACC_TRIM_X: trim_x = cfg_data;
					REG_ACC_TRIM_Y: trim_y = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				rx = negated(rate_x_raw) - longint'(off_x);
				ry = negated(rate_y_raw) - longint'(off_y);
				rz = negated(rate_z_raw) - longint'(off_z);
				ax = negated(acc_x_raw);
				ay = negated(acc_y_raw);
				az = negated(acc_z_raw);
				run_x = clamp32(run_x + round_shift(rx * RATE_DEG_Q32, GYRO_SHIFT));
				run_y = clamp32(run_y + round_shift(ry * RATE_DEG_Q32, GYRO_SHIFT));
				// yaw moves angle between the axes
				s30 = yaw_sin(rz);
				mx = round_shift(run_y * s30, 30);
				my = round_shift(run_x * s30, 30);
				run_x = clamp32(run_x + mx);
				run_y = clamp32(run_y - my);
				norm = int_root(longint'(ax * ax) + longint'(ay * ay) + longint'(az * az));
				ex = -round_shift(tilt_deg(ax, norm), ACC_SHIFT) - longint'(trim_x);
				ey = round_shift(tilt_deg(ay, norm), ACC_SHIFT) - longint'(trim_y);
				if (started) begin
					run_x = clamp32(round_shift(run_x * BLEND_OLD + ex * BLEND_NEW, 30));
					run_y = clamp32(round_shift(run_y * BLEND_OLD + ey * BLEND_NEW, 30));
				end else begin
					run_x = clamp32(ex);
					run_y = clamp32(ey);
					started = 1;
				end
				p.x = run_x[31:0];
				p.y = 32'(clamp32(-run_y));
				expected_tilts.push_back(p);
			end
			if (out_valid && !out_stall) begin
				if (expected_tilts.size() == 0) begin
					$display("unexpected output item at %0t", $realtime);
					fail_count++;
				end else begin
					got = expected_tilts.pop_front();
					if (tilt_x !== got.x) report("tilt_x", tilt_x, got.x);
					if (tilt_y !== got.y) report("tilt_y", tilt_y, got.y);
				end
			end
		end
	end

endmodule

FILE: tb/sv/imu_complementary_filter_top_test.sv
// testbench top for the imu tilt estimator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module imu_complementary_filter_top_test
	import imu_cf_pkg::*;
();

	localparam logic [2:0] REG_SPARE_5 = 3'd5;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE      = 200;
	localparam int TRIM_HI     = 11796480;

	logic clk = 0, arst_n = 0;
	logic cfg_wr_en = 0;
	logic [2:0] cfg_index = '0;
	logic [24:0] cfg_data = '0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [15:0] acc_x_raw = '0, acc_y_raw = '0, acc_z_raw = '0;
	logic [15:0] rate_x_raw = '0, rate_y_raw = '0, rate_z_raw = '0;
	logic signed [31:0] tilt_x, tilt_y;
	int fail_count, pending, quiet, stall_ctr;

	imu_complementary_filter_top dut (.*);

	imu_complementary_filter_checker chk (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver stalls: calm stretches alternate with busy ones
	always @(posedge clk) begin
		stall_ctr <= stall_ctr + 1;
		if (stall_ctr[9:8] == 2'd0) out_stall <= 1'b0;
		else if (stall_ctr[9:8] == 2'd3) out_stall <= ($urandom_range(0, 1) == 0);
		else out_stall <= ($urandom_range(0, 5) == 0);
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_regs(input logic [2:0] idx[], input logic [24:0] val[]);
		foreach (idx[i]) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_sample(input logic [15:0] w[6]);
		in_valid   <= 1'b1;
		acc_x_raw  <= w[0];
		acc_y_raw  <= w[1];
		acc_z_raw  <= w[2];
		rate_x_raw <= w[3];
		rate_y_raw <= w[4];
		rate_z_raw <= w[5];
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [15:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h7fff;
			2: return 16'h8000;
			3: return 16'hffff;
			4: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly plausible sensor samples, some full-range noise and corner words
	function automatic void random_sample(output logic [15:0] w[6]);
		int kind;
		kind = $urandom_range(0, 15);
		for (int i = 0; i < 6; i++) begin
			if (kind < 9) w[i] = (i == 2) ? 16'($signed(16'd16384) + $signed(16'($urandom_range(0, 4000)) - 16'sd2000))
				: 16'($urandom_range(0, 8000) - 4000);
			else if (kind < 13) w[i] = 16'($urandom);
			else w[i] = edge_word();
		end
		if (kind == 15) begin
			w[0] = '0;
			w[1] = '0;
			w[2] = '0;
		end
	endfunction

	task automatic run_items(input int count);
		logic [15:0] w[6];
		int left, burst, gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 10);
			for (int b = 0; b < burst && left > 0; b++) begin
				random_sample(w);
				send_sample(w);
				left--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] w[6];
		logic [15:0] corners[6];
		corners = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 16'h5555};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: the first sample seeds, then corner words on every field
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 6; i++) w[i] = corners[(k + i) % 6];
			send_sample(w);
		end
		// zero norm keeps only the trims
		w = '{16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h8000};
		send_sample(w);
		w = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
		send_sample(w);
		// single axis full scale, and strong yaw
		w = '{16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff};
		send_sample(w);
		w = '{16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h8000};
		send_sample(w);
		w = '{16'h0000, 16'h0000, 16'h7fff, 16'hffff, 16'hffff, 16'hffff};
		send_sample(w);
		in_valid <= 1'b0;
		drain();

		// offsets and trims at their lowest, unused indices ignored
		write_regs('{REG_GYRO_OFF_X, REG_GYRO_OFF_Y, REG_GYRO_OFF_Z, REG_ACC_TRIM_X,
			REG_ACC_TRIM_Y, REG_SPARE_5, REG_SPARE_7},
			'{25'h8000, 25'h8000, 25'h8000, 25'(-TRIM_HI), 25'(-TRIM_HI), 25'h1ffffff, 25'h0});
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 6; i++) w[i] = corners[(k + 2 * i) % 6];
			send_sample(w);
		end
		run_items(200);
		drain();

		// highest values
		write_regs('{REG_GYRO_OFF_X, REG_GYRO_OFF_Y, REG_GYRO_OFF_Z, REG_ACC_TRIM_X,
			REG_ACC_TRIM_Y},
			'{25'h7fff, 25'h7fff, 25'h7fff, 25'(TRIM_HI), 25'(TRIM_HI)});
		run_items(200);
		drain();

		// random settings
		for (int ph = 0; ph < 3; ph++) begin
			write_regs('{REG_GYRO_OFF_X, REG_GYRO_OFF_Y, REG_GYRO_OFF_Z, REG_ACC_TRIM_X,
				REG_ACC_TRIM_Y},
				'{25'($urandom_range(0, 600) - 300), 25'($urandom),
				25'($urandom_range(0, 600) - 300),
				25'($urandom_range(0, 2 * TRIM_HI) - TRIM_HI),
				25'($urandom_range(0, 2 * TRIM_HI) - TRIM_HI)});
			run_items(230);
			drain();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
